FILE: sv/gdet_pkg.sv
package gdet_pkg;

    localparam int CHAR_W = 8;
    localparam int GRID_W_BITS = 11;
    localparam int CFG_DATA_W = 11;

    localparam logic [CHAR_W-1:0] RESET_FIRST_LETTER = 8'd112;
    localparam logic [CHAR_W-1:0] RESET_MIDDLE_LETTER = 8'd105;
    localparam logic [CHAR_W-1:0] RESET_FINAL_LETTER = 8'd101;
    localparam logic [GRID_W_BITS-1:0] RESET_GRID_WIDTH = 11'd1024;

    typedef enum logic [1:0]
    {
        CFG_FIRST_LETTER,
        CFG_MIDDLE_LETTER,
        CFG_FINAL_LETTER,
        CFG_GRID_WIDTH
    } cfg_index_t;

    typedef struct packed
    {
        logic [CHAR_W-1:0] cell_char;
        logic              last_cell;
    } in_t;

    typedef struct packed
    {
        logic match_here;
        logic found_so_far;
        logic grid_done;
    } out_t;

    // One entry of the line store: the cells two rows and one row above.
    typedef struct packed
    {
        logic [CHAR_W-1:0] upper;
        logic [CHAR_W-1:0] middle;
    } column_pair_t;

endpackage

FILE: sv/gdet_line_store.sv
module gdet_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output gdet_pkg::column_pair_t      rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  gdet_pkg::column_pair_t      wr_data
);

    gdet_pkg::column_pair_t mem [MAX_WIDTH];

    gdet_pkg::column_pair_t rd_data_reg;
    gdet_pkg::column_pair_t fwd_data_reg;
    logic                   fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // A read that collides with the write of the same edge would see the old
    // entry, so the written data is kept and substituted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

FILE: sv/grid_three_cell_word_detector_core.sv
// Each cell is taken into the stage-one registers; its result moves to the
// output register when stage one advances and is held until it is taken.
// Throughput: one cell per cycle unless the output stalls; the line store is read
// as a cell is taken, written as it leaves stage one, forwarded on a column clash.
// Reset clears the window, counters, found flag and handshake state and loads
// the word "pie" with a grid width of 1024; line store contents stay undefined.
module grid_three_cell_word_detector_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  gdet_pkg::cfg_index_t                  cfg_index,
    input  logic [gdet_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  gdet_pkg::in_t                         in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output gdet_pkg::out_t                        out_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > gdet_pkg::GRID_W_BITS) ? AW + 1 : gdet_pkg::GRID_W_BITS;
    localparam int CW = gdet_pkg::CHAR_W;

    logic [CW-1:0]                     first_letter_reg;
    logic [CW-1:0]                     middle_letter_reg;
    logic [CW-1:0]                     final_letter_reg;
    logic [gdet_pkg::GRID_W_BITS-1:0]  grid_width_reg;

    logic [AW-1:0] col_reg, col_next;
    logic [1:0]    row_cnt_reg, row_cnt_next;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_char_reg;
    logic          s1_last_reg;
    logic          s1_col_ok_reg;
    logic          s1_row_ok_reg;
    logic [AW-1:0] s1_addr_reg;

    logic [CW-1:0] win0_reg, win2_reg, win3_reg, win4_reg, win5_reg;
    logic          found_reg;

    logic           out_valid_reg;
    gdet_pkg::out_t out_data_reg;

    logic [WW-1:0] width_raw, width_eff, col_inc;
    logic          row_end;
    logic          accept;
    logic          s1_adv;
    logic          hit;
    logic          found_now;

    gdet_pkg::column_pair_t rd_pair;
    gdet_pkg::column_pair_t wr_pair;

    function automatic logic line_hit(
        input logic [CW-1:0] a,
        input logic [CW-1:0] b,
        input logic [CW-1:0] c,
        input logic [CW-1:0] first_l,
        input logic [CW-1:0] middle_l,
        input logic [CW-1:0] final_l
    );
        line_hit = (b == middle_l) &&
                   (((a == first_l) && (c == final_l)) ||
                    ((a == final_l) && (c == first_l)));
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_letter_reg  <= gdet_pkg::RESET_FIRST_LETTER;
            middle_letter_reg <= gdet_pkg::RESET_MIDDLE_LETTER;
            final_letter_reg  <= gdet_pkg::RESET_FINAL_LETTER;
            grid_width_reg    <= gdet_pkg::RESET_GRID_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gdet_pkg::CFG_FIRST_LETTER:  first_letter_reg  <= cfg_data[CW-1:0];
                gdet_pkg::CFG_MIDDLE_LETTER: middle_letter_reg <= cfg_data[CW-1:0];
                gdet_pkg::CFG_FINAL_LETTER:  final_letter_reg  <= cfg_data[CW-1:0];
                gdet_pkg::CFG_GRID_WIDTH:    grid_width_reg    <= cfg_data;
                default:                     first_letter_reg  <= first_letter_reg;
            endcase
        end
    end

    // Handshake control.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    // Position counters advance when a cell is taken.
    always_comb
    begin
        width_raw = WW'(grid_width_reg);
        if (width_raw == '0)
        begin
            width_eff = WW'(1);
        end
        else if (width_raw > WW'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_raw;
        end
        col_inc = WW'(col_reg) + WW'(1);
        row_end = col_inc >= width_eff;

        col_next     = col_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (in_data.last_cell)
            begin
                col_next     = '0;
                row_cnt_next = 2'd0;
            end
            else if (row_end)
            begin
                col_next = '0;
                if (row_cnt_reg != 2'd2)
                begin
                    row_cnt_next = row_cnt_reg + 2'd1;
                end
            end
            else
            begin
                col_next = col_inc[AW-1:0];
            end
        end
    end

    gdet_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_pair),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_pair)
    );

    // The rows shift down by one: the middle row becomes the upper one.
    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = s1_char_reg;

    // Row, column, diagonal and antidiagonal checks, each in both directions.
    always_comb
    begin
        hit = 1'b0;
        if (s1_col_ok_reg &&
            line_hit(win2_reg, win5_reg, s1_char_reg,
                     first_letter_reg, middle_letter_reg, final_letter_reg))
        begin
            hit = 1'b1;
        end
        if (s1_row_ok_reg &&
            line_hit(rd_pair.upper, rd_pair.middle, s1_char_reg,
                     first_letter_reg, middle_letter_reg, final_letter_reg))
        begin
            hit = 1'b1;
        end
        if (s1_col_ok_reg && s1_row_ok_reg)
        begin
            if (line_hit(win0_reg, win4_reg, s1_char_reg,
                         first_letter_reg, middle_letter_reg, final_letter_reg))
            begin
                hit = 1'b1;
            end
            if (line_hit(rd_pair.upper, win4_reg, win2_reg,
                         first_letter_reg, middle_letter_reg, final_letter_reg))
            begin
                hit = 1'b1;
            end
        end
        found_now = found_reg || hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_cnt_reg   <= 2'd0;
            s1_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            win0_reg      <= '0;
            win2_reg      <= '0;
            win3_reg      <= '0;
            win4_reg      <= '0;
            win5_reg      <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_cnt_reg <= row_cnt_next;

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                if (s1_last_reg)
                begin
                    found_reg <= 1'b0;
                    win0_reg  <= '0;
                    win2_reg  <= '0;
                    win3_reg  <= '0;
                    win4_reg  <= '0;
                    win5_reg  <= '0;
                end
                else
                begin
                    found_reg <= found_now;
                    win0_reg  <= win3_reg;
                    win2_reg  <= win5_reg;
                    win3_reg  <= rd_pair.upper;
                    win4_reg  <= rd_pair.middle;
                    win5_reg  <= s1_char_reg;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_char_reg   <= in_data.cell_char;
            s1_last_reg   <= in_data.last_cell;
            s1_col_ok_reg <= col_reg >= AW'(2);
            s1_row_ok_reg <= row_cnt_reg == 2'd2;
            s1_addr_reg   <= col_reg;
        end
        if (s1_adv)
        begin
            out_data_reg.match_here   <= hit;
            out_data_reg.found_so_far <= found_now;
            out_data_reg.grid_done    <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_stall_only_when_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg)
    ) else $error("input stalled while the pipeline could move");

    a_result_follows_advance: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg
    ) else $error("advanced transaction did not reach the output register");

    a_grid_end_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && in_data.last_cell) |=> (col_reg == '0 && row_cnt_reg == 2'd0)
    ) else $error("position counters not cleared after the last cell");

    a_match_sets_found: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.match_here) |-> out_data.found_so_far
    ) else $error("match reported without the found flag");

    a_row_count_saturates: assert property (
        @(posedge clk) disable iff (!rst_n)
        row_cnt_reg != 2'd3
    ) else $error("row counter passed its saturation value");

endmodule

FILE: bench/testbench.sv
module testbench;

    localparam int LINE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 300000;
    localparam int CHAR_W = gdet_pkg::CHAR_W;
    localparam int GRID_W_BITS = gdet_pkg::GRID_W_BITS;
    localparam int CFG_DATA_W = gdet_pkg::CFG_DATA_W;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    gdet_pkg::cfg_index_t cfg_index = gdet_pkg::CFG_FIRST_LETTER;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    gdet_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    gdet_pkg::out_t out_data;

    // Predicted state of the detector.
    logic [CHAR_W-1:0] word_first = gdet_pkg::RESET_FIRST_LETTER;
    logic [CHAR_W-1:0] word_middle = gdet_pkg::RESET_MIDDLE_LETTER;
    logic [CHAR_W-1:0] word_final = gdet_pkg::RESET_FINAL_LETTER;
    logic [GRID_W_BITS-1:0] width_setting = gdet_pkg::RESET_GRID_WIDTH;
    logic [CHAR_W-1:0] upper_line [LINE_DEPTH] = '{default: '0};
    logic [CHAR_W-1:0] middle_line [LINE_DEPTH] = '{default: '0};
    logic [CHAR_W-1:0] window_bytes [6] = '{default: '0};
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic seen_word = 1'b0;

    gdet_pkg::out_t awaited_flags [$];
    gdet_pkg::out_t next_flags;
    int unsigned mismatch_count = 0;
    bit steady_flow = 1'b0;
    bit hold_pending = 1'b0;
    int unsigned hold_cycles_left = 0;

    grid_three_cell_word_detector_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned effective_width();
        if (width_setting == 0)
            return 1;
        if (width_setting > LINE_DEPTH)
            return LINE_DEPTH;
        return int'(width_setting);
    endfunction

    function automatic logic word_on_line(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b,
                                          logic [CHAR_W-1:0] c);
        if (b != word_middle)
            return 1'b0;
        return (a == word_first && c == word_final) || (a == word_final && c == word_first);
    endfunction

    // Works out the flags for one cell and advances the predicted window state.
    function automatic gdet_pkg::out_t score_cell(gdet_pkg::in_t item);
        int unsigned cols;
        int unsigned c;
        logic [CHAR_W-1:0] up;
        logic [CHAR_W-1:0] mid;
        logic [CHAR_W-1:0] cur;
        logic hit;
        gdet_pkg::out_t res;
        cols = effective_width();
        c = col_pos;
        cur = item.cell_char;
        up = upper_line[c];
        mid = middle_line[c];
        hit = 1'b0;
        if (c >= 2 && word_on_line(window_bytes[2], window_bytes[5], cur))
            hit = 1'b1;
        if (row_pos == 2 && word_on_line(up, mid, cur))
            hit = 1'b1;
        if (c >= 2 && row_pos == 2 &&
            (word_on_line(window_bytes[0], window_bytes[4], cur) ||
             word_on_line(up, window_bytes[4], window_bytes[2])))
            hit = 1'b1;
        upper_line[c] = mid;
        middle_line[c] = cur;
        window_bytes[0] = window_bytes[3];
        window_bytes[1] = window_bytes[4];
        window_bytes[2] = window_bytes[5];
        window_bytes[3] = up;
        window_bytes[4] = mid;
        window_bytes[5] = cur;
        if (c + 1 >= cols)
        begin
            col_pos = 0;
            if (row_pos < 2)
                row_pos++;
        end
        else
            col_pos = c + 1;
        seen_word = seen_word | hit;
        res.match_here = hit;
        res.found_so_far = seen_word;
        res.grid_done = item.last_cell;
        if (item.last_cell)
        begin
            window_bytes = '{default: '0};
            col_pos = 0;
            row_pos = 0;
            seen_word = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return word_first;
        if (roll < 50)
            return word_middle;
        if (roll < 75)
            return word_final;
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic send_cell(input logic [CHAR_W-1:0] ch, input logic last);
        gdet_pkg::in_t item;
        item.cell_char = ch;
        item.last_cell = last;
        while (!steady_flow && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited_flags.push_back(score_cell(item));
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_cell(s[i], i == s.len() - 1);
    endtask

    task automatic send_random_grid(input int unsigned rows, input bit may_cut,
                                    output int unsigned total);
        int unsigned i;
        total = rows * effective_width();
        if (may_cut && $urandom_range(99) < 15)
            total = $urandom_range(total, 1);
        for (i = 0; i < total; i++)
            send_cell(pick_char(), i == total - 1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called with the block idle; all four registers are written each time.
    task automatic configure(input logic [CHAR_W-1:0] a, input logic [CHAR_W-1:0] b,
                             input logic [CHAR_W-1:0] c, input logic [GRID_W_BITS-1:0] w);
        cfg_we <= 1'b1;
        cfg_index <= gdet_pkg::CFG_FIRST_LETTER;
        cfg_data <= CFG_DATA_W'(a);
        @(posedge clk);
        cfg_index <= gdet_pkg::CFG_MIDDLE_LETTER;
        cfg_data <= CFG_DATA_W'(b);
        @(posedge clk);
        cfg_index <= gdet_pkg::CFG_FINAL_LETTER;
        cfg_data <= CFG_DATA_W'(c);
        @(posedge clk);
        cfg_index <= gdet_pkg::CFG_GRID_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        word_first = a;
        word_middle = b;
        word_final = c;
        width_setting = w;
    endtask

    task automatic test_directed_words();
        drain_results();
        configure(gdet_pkg::RESET_FIRST_LETTER, gdet_pkg::RESET_MIDDLE_LETTER,
                  gdet_pkg::RESET_FINAL_LETTER, 11'd3);
        // Row, column, reversed column and reversed row all in one grid.
        send_text("pieiiieip");
        // Reversed diagonal and forward antidiagonal meet at the last cell.
        send_text("expxixexp");
        // A grid that ends part way along its first row.
        send_text("pi");
        drain_results();
        configure(gdet_pkg::RESET_FIRST_LETTER, gdet_pkg::RESET_MIDDLE_LETTER,
                  gdet_pkg::RESET_FINAL_LETTER, 11'd1);
        send_text("pie");
        drain_results();
        // A width of zero behaves as a single column.
        configure(gdet_pkg::RESET_FIRST_LETTER, gdet_pkg::RESET_MIDDLE_LETTER,
                  gdet_pkg::RESET_FINAL_LETTER, 11'd0);
        send_text("eip");
    endtask

    task automatic test_wide_grids();
        int unsigned i;
        drain_results();
        // Above the largest width, the block clamps to the line store depth.
        configure(gdet_pkg::RESET_FIRST_LETTER, gdet_pkg::RESET_MIDDLE_LETTER,
                  gdet_pkg::RESET_FINAL_LETTER, 11'd2047);
        for (i = 0; i < LINE_DEPTH + 6; i++)
            send_cell(pick_char(), i == LINE_DEPTH + 5);
    endtask

    task automatic test_byte_extremes();
        int unsigned count;
        drain_results();
        configure(8'h00, 8'hFF, 8'h00, 11'd4);
        send_random_grid(4, 1'b0, count);
        drain_results();
        configure(8'hFF, 8'h00, 8'hFF, 11'd2);
        send_random_grid(6, 1'b0, count);
    endtask

    task automatic test_receiver_hold();
        int unsigned count;
        drain_results();
        configure(gdet_pkg::RESET_FIRST_LETTER, gdet_pkg::RESET_MIDDLE_LETTER,
                  gdet_pkg::RESET_FINAL_LETTER, 11'd5);
        hold_pending = 1'b1;
        send_random_grid(8, 1'b0, count);
    endtask

    task automatic test_random_grids();
        int unsigned sent;
        int unsigned count;
        int unsigned roll;
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;
        logic [CHAR_W-1:0] c;
        logic [GRID_W_BITS-1:0] w;
        sent = 0;
        while (sent < 800)
        begin
            if (sent == 0 || $urandom_range(1) == 0)
            begin
                drain_results();
                a = CHAR_W'($urandom_range(255));
                b = CHAR_W'($urandom_range(255));
                c = CHAR_W'($urandom_range(255));
                roll = $urandom_range(99);
                if (roll < 10)
                begin
                    b = a;
                    c = a;
                end
                else if (roll < 25)
                    c = a;
                roll = $urandom_range(99);
                if (roll < 70)
                    w = GRID_W_BITS'($urandom_range(6, 1));
                else if (roll < 92)
                    w = GRID_W_BITS'($urandom_range(40, 7));
                else
                    w = '0;
                configure(a, b, c, w);
            end
            // One long stretch in which neither side idles.
            steady_flow = (sent >= 250 && sent < 550);
            send_random_grid($urandom_range(7, 1), 1'b1, count);
            sent += count;
        end
        steady_flow = 1'b0;
    endtask

    // Receiver side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles_left > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles_left--;
            end
            else if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_cycles_left = 300;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady_flow && ($urandom_range(99) < 19);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_flags.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: match=%b found=%b done=%b",
                             out_data.match_here, out_data.found_so_far, out_data.grid_done);
            end
            else
            begin
                next_flags = awaited_flags.pop_front();
                if (out_data.match_here !== next_flags.match_here ||
                    out_data.found_so_far !== next_flags.found_so_far ||
                    out_data.grid_done !== next_flags.grid_done)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("flags differ: expected match=%b found=%b done=%b, %s%b %s%b %s%b",
                                 next_flags.match_here, next_flags.found_so_far,
                                 next_flags.grid_done,
                                 "got match=", out_data.match_here,
                                 "found=", out_data.found_so_far,
                                 "done=", out_data.grid_done);
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_words();
        test_byte_extremes();
        test_receiver_hold();
        test_wide_grids();
        test_random_grids();
        drain_results();
        if (mismatch_count == 0 && awaited_flags.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: grid_three_cell_word_detector_core.f
sv/gdet_pkg.sv
sv/gdet_line_store.sv
sv/grid_three_cell_word_detector_core.sv
bench/testbench.sv
